@@ rtl/acpu_pkg.sv @@
// package for the accumulator cpu core: field widths, codes, helpers
// no dependencies
package acpu_pkg;
  localparam int MemAddrBits = 16;
  localparam int MemBytes = 1 << MemAddrBits;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_INIT = 2'd2;
  localparam logic [1:0] KIND_STEP = 2'd3;

  localparam logic [0:0] CFG_SP = 1'b0;
  localparam logic [0:0] CFG_PC = 1'b1;

  localparam logic [3:0] X_AC = 4'd4;
  localparam logic [3:0] X_SP = 4'd5;
  localparam logic [3:0] X_BP = 4'd6;
  localparam logic [3:0] X_PC = 4'd7;
  localparam logic [3:0] X_IR = 4'd8;

  // instruction groups, bits 15:14
  localparam logic [1:0] GRP_FLOW = 2'd0;
  localparam logic [1:0] GRP_XFER = 2'd1;
  localparam logic [1:0] GRP_ALU = 2'd2;
  localparam logic [1:0] GRP_JUMP = 2'd3;

  // flow ops, bits 12:11
  localparam logic [1:0] FLOW_HALT = 2'd0;
  localparam logic [1:0] FLOW_NOP = 2'd1;
  localparam logic [1:0] FLOW_RET = 2'd2;

  // transfer ops, bits 13:11
  localparam logic [2:0] XFER_LODI = 3'd0;
  localparam logic [2:0] XFER_LODA = 3'd1;
  localparam logic [2:0] XFER_LODR = 3'd2;
  localparam logic [2:0] XFER_LODRD = 3'd3;
  localparam logic [2:0] XFER_STOA = 3'd4;
  localparam logic [2:0] XFER_STOR = 3'd5;
  localparam logic [2:0] XFER_STORD = 3'd6;

  // manipulate ops, bits 13:11
  localparam logic [2:0] ALU_NEG = 3'd0;
  localparam logic [2:0] ALU_ADD = 3'd1;
  localparam logic [2:0] ALU_ADDI = 3'd2;
  localparam logic [2:0] ALU_SUB = 3'd3;
  localparam logic [2:0] ALU_SUBI = 3'd4;
  localparam logic [2:0] ALU_MOV = 3'd7;

  // jump conditions, bits 13:12
  localparam logic [1:0] JMP_ALWAYS = 2'd0;
  localparam logic [1:0] JMP_ZERO = 2'd1;
  localparam logic [1:0] JMP_NEG = 2'd2;
  localparam logic [1:0] JMP_CALL = 2'd3;

  function automatic logic [15:0] sext8(input logic [15:0] v);
    return {{8{v[7]}}, v[7:0]};
  endfunction

  function automatic logic [15:0] sext5(input logic [15:0] v);
    return {{11{v[4]}}, v[4:0]};
  endfunction
endpackage

@@ rtl/accumulator_cpu_16bit_core.sv @@
// top level of the accumulator cpu core: register file, byte memory, sequencer
// depends on acpu_pkg
//
// channel  direction  handshake          payload
// in       input      in_valid/in_ready  kind, mem_address, write_data, reg_select
// out      output     out_valid/out_ready read_data, reg_value, program_counter,
//                                        accumulator, halted, fault
// cfg      input      cfg_we             cfg_index, cfg_data
//
// after reset a clearing pass writes zero to all 65536 bytes, one per cycle, in_ready low.
// the byte memory has one port with registered read: a word read passes RD_LO, RD_HI and
// RD_WAIT, a write WR_LO and WR_HI. init and a halted step go straight to the result; a step
// fetches, decodes, then may access words; in_ready returns as the result is loaded.
// the output register parts the sides: the next beat is taken while a result waits, and a
// finished beat holds in its last state until out_ready frees the register.
module accumulator_cpu_16bit_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [15:0] mem_address,
  input  logic [15:0] write_data,
  input  logic [3:0]  reg_select,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] read_data,
  output logic [15:0] reg_value,
  output logic [15:0] program_counter,
  output logic [15:0] accumulator,
  output logic        halted,
  output logic        fault,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import acpu_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD_LO, S_RD_HI, S_RD_WAIT, S_WR_LO, S_WR_HI,
    S_DECODE, S_DONE
  } state_t;

  // what to do after a word access finishes
  typedef enum logic [2:0] {
    N_READ, N_FETCH, N_LOAD, N_RET1, N_RET2, N_CALL1, N_NONE
  } next_t;

  state_t state;
  next_t nxt;
  logic [7:0] mem [MemBytes];
  logic [7:0] mem_q;
  logic [15:0] regs [9];
  logic [15:0] cfg_sp, cfg_pc;
  logic hflag, eflag;
  logic [15:0] addr, wdata, word;
  logic [3:0] sel;
  logic [2:0] dst;
  logic [1:0] ikind;
  logic [MemAddrBits-1:0] clr_addr;

  // memory port, driven by the sequencer
  logic mem_we;
  logic [MemAddrBits-1:0] mem_a;
  logic [7:0] mem_d;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_a] <= mem_d;
    mem_q <= mem[mem_a];
  end

  logic [15:0] addr_p1;
  assign addr_p1 = addr + 16'd1;

  always_comb begin
    mem_we = 1'b0;
    mem_a = addr[MemAddrBits-1:0];
    mem_d = wdata[7:0];
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_a = clr_addr;
        mem_d = 8'd0;
      end
      S_RD_HI: mem_a = addr_p1[MemAddrBits-1:0];
      S_WR_LO: mem_we = 1'b1;
      S_WR_HI: begin
        mem_we = 1'b1;
        mem_a = addr_p1[MemAddrBits-1:0];
        mem_d = wdata[15:8];
      end
      default: ;
    endcase
  end

  assign in_ready = (state == S_IDLE);

  // word being read: high byte straight from the memory, low byte captured before
  logic [15:0] rd_word;
  assign rd_word = {mem_q, word[7:0]};

  // instruction decode from the fetched word, pc already advanced
  logic [15:0] ir;
  logic [3:0] ra_i, rb_i;
  logic [15:0] ra_v, rb_v, imm8, disp5, tgt;
  assign ir = regs[X_IR];
  assign ra_i = {1'b0, ir[10:8]};
  assign rb_i = {1'b0, ir[7:5]};
  assign ra_v = regs[ra_i];
  assign rb_v = regs[rb_i];
  assign imm8 = sext8(ir);
  assign disp5 = sext5(ir);
  assign tgt = {4'd0, ir[11:0]};

  logic [15:0] out_sel;
  always_comb begin
    out_sel = (sel <= X_IR) ? regs[sel] : 16'd0;
  end

  // a finished beat loads the output register once the previous one has left
  logic out_load;
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      out_valid <= 1'b0;
      hflag <= 1'b0;
      eflag <= 1'b0;
      cfg_sp <= 16'd0;
      cfg_pc <= 16'd0;
      for (int i = 0; i < 9; i++) regs[i] <= 16'd0;
      nxt <= N_NONE;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SP: cfg_sp <= cfg_data;
          CFG_PC: cfg_pc <= cfg_data;
          default: ;
        endcase
      end
      // output register
      if (out_load) begin
        read_data <= (ikind == KIND_READ) ? word : 16'd0;
        reg_value <= out_sel;
        program_counter <= regs[X_PC];
        accumulator <= regs[X_AC];
        halted <= hflag;
        fault <= eflag;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            ikind <= kind;
            sel <= reg_select;
            addr <= (kind == KIND_STEP) ? regs[X_PC] : mem_address;
            wdata <= write_data;
            case (kind)
              KIND_WRITE: begin
                nxt <= N_NONE;
                state <= S_WR_LO;
              end
              KIND_READ: begin
                nxt <= N_READ;
                state <= S_RD_LO;
              end
              KIND_INIT: begin
                for (int i = 0; i < 9; i++) begin
                  if (4'(i) == X_SP) regs[i] <= cfg_sp;
                  else if (4'(i) == X_BP) regs[i] <= cfg_sp - 16'd2;
                  else if (4'(i) == X_PC) regs[i] <= cfg_pc;
                  else regs[i] <= 16'd0;
                end
                hflag <= 1'b0;
                eflag <= 1'b0;
                state <= S_DONE;
              end
              default: begin
                if (hflag) state <= S_DONE;
                else begin
                  nxt <= N_FETCH;
                  state <= S_RD_LO;
                end
              end
            endcase
          end
        end
        S_RD_LO: state <= S_RD_HI;
        S_RD_HI: begin
          word[7:0] <= mem_q;
          state <= S_RD_WAIT;
        end
        // word complete: finish the access that asked for it
        S_RD_WAIT: begin
          word <= rd_word;
          case (nxt)
            N_FETCH: begin
              regs[X_IR] <= rd_word;
              regs[X_PC] <= regs[X_PC] + 16'd2;
              state <= S_DECODE;
            end
            N_LOAD: begin
              regs[{1'b0, dst}] <= rd_word;
              state <= S_DONE;
            end
            N_RET1: begin
              regs[X_BP] <= rd_word;
              regs[X_SP] <= regs[X_SP] - 16'd2;
              addr <= regs[X_SP] - 16'd2;
              nxt <= N_RET2;
              state <= S_RD_LO;
            end
            N_RET2: begin
              regs[X_PC] <= rd_word;
              state <= S_DONE;
            end
            default: state <= S_DONE;
          endcase
        end
        S_WR_LO: state <= S_WR_HI;
        S_WR_HI: begin
          if (nxt == N_CALL1) begin
            // second call word: old base pointer
            addr <= regs[X_SP];
            wdata <= regs[X_BP];
            regs[X_BP] <= regs[X_SP];
            regs[X_SP] <= regs[X_SP] + 16'd2;
            nxt <= N_NONE;
            state <= S_WR_LO;
          end else state <= S_DONE;
        end
        S_DECODE: begin
          case (ir[15:14])
            GRP_FLOW: begin
              case (ir[12:11])
                FLOW_HALT: begin
                  hflag <= 1'b1;
                  state <= S_DONE;
                end
                FLOW_NOP: state <= S_DONE;
                FLOW_RET: begin
                  regs[X_SP] <= regs[X_BP];
                  addr <= regs[X_BP];
                  nxt <= N_RET1;
                  state <= S_RD_LO;
                end
                default: begin
                  eflag <= 1'b1;
                  state <= S_DONE;
                end
              endcase
            end
            GRP_XFER: begin
              dst <= ir[10:8];
              case (ir[13:11])
                XFER_LODI: begin
                  regs[ra_i] <= imm8;
                  state <= S_DONE;
                end
                XFER_LODA: begin
                  addr <= imm8;
                  nxt <= N_LOAD;
                  state <= S_RD_LO;
                end
                XFER_LODR: begin
                  addr <= rb_v;
                  nxt <= N_LOAD;
                  state <= S_RD_LO;
                end
                XFER_LODRD: begin
                  addr <= rb_v + disp5;
                  nxt <= N_LOAD;
                  state <= S_RD_LO;
                end
                XFER_STOA: begin
                  addr <= imm8;
                  wdata <= ra_v;
                  nxt <= N_NONE;
                  state <= S_WR_LO;
                end
                XFER_STOR: begin
                  addr <= rb_v;
                  wdata <= ra_v;
                  nxt <= N_NONE;
                  state <= S_WR_LO;
                end
                XFER_STORD: begin
                  addr <= rb_v + disp5;
                  wdata <= ra_v;
                  nxt <= N_NONE;
                  state <= S_WR_LO;
                end
                default: begin
                  eflag <= 1'b1;
                  state <= S_DONE;
                end
              endcase
            end
            GRP_ALU: begin
              state <= S_DONE;
              case (ir[13:11])
                ALU_NEG: regs[X_AC] <= 16'd0 - ra_v;
                ALU_ADD: regs[X_AC] <= ra_v + rb_v;
                ALU_ADDI: regs[X_AC] <= ra_v + imm8;
                ALU_SUB: regs[X_AC] <= ra_v - rb_v;
                ALU_SUBI: regs[X_AC] <= ra_v - imm8;
                ALU_MOV: regs[ra_i] <= rb_v;
                default: eflag <= 1'b1;
              endcase
            end
            default: begin
              case (ir[13:12])
                JMP_ALWAYS: begin
                  regs[X_PC] <= tgt;
                  state <= S_DONE;
                end
                JMP_ZERO: begin
                  if (regs[X_AC] == 16'd0) regs[X_PC] <= tgt;
                  state <= S_DONE;
                end
                JMP_NEG: begin
                  if (regs[X_AC][15]) regs[X_PC] <= tgt;
                  state <= S_DONE;
                end
                default: begin
                  // first call word: return address
                  addr <= regs[X_SP];
                  wdata <= regs[X_PC];
                  regs[X_SP] <= regs[X_SP] + 16'd2;
                  regs[X_PC] <= tgt;
                  nxt <= N_CALL1;
                  state <= S_WR_LO;
                end
              endcase
            end
          endcase
        end
        S_DONE: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ tb/acpu_core_checker.sv @@
// result checker for the accumulator cpu core: watches the input, config and
// output channels, predicts each result and compares it; depends on acpu_pkg
module acpu_core_checker
  import acpu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [15:0] mem_address,
  input  logic [15:0] write_data,
  input  logic [3:0]  reg_select,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] read_data,
  input  logic [15:0] reg_value,
  input  logic [15:0] program_counter,
  input  logic [15:0] accumulator,
  input  logic        halted,
  input  logic        fault,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic [15:0] rd;
    logic [15:0] rv;
    logic [15:0] pc;
    logic [15:0] ac;
    logic        hlt;
    logic        flt;
  } core_result_t;

  core_result_t expected_results[$];
  logic [7:0]   mem_bytes[MemBytes];
  logic [15:0]  reg_file[9];
  logic         core_halted;
  logic         core_fault;
  logic [15:0]  init_sp;
  logic [15:0]  init_pc;
  int           error_count = 0;

  function automatic logic [MemAddrBits-1:0] byte_index(input logic [15:0] a);
    return a[MemAddrBits-1:0];
  endfunction

  function automatic logic [15:0] load_word(input logic [15:0] a);
    return {mem_bytes[byte_index(a + 16'd1)], mem_bytes[byte_index(a)]};
  endfunction

  function automatic void store_word(input logic [15:0] a, input logic [15:0] v);
    mem_bytes[byte_index(a)] = v[7:0];
    mem_bytes[byte_index(a + 16'd1)] = v[15:8];
  endfunction

  // one instruction: fetch, bump pc, decode, execute
  function automatic void execute_instruction();
    logic [15:0] ir;
    logic [15:0] imm;
    logic [15:0] disp;
    logic [15:0] tgt;
    logic [3:0]  ra;
    logic [3:0]  rb;
    if (core_halted) return;
    ir = load_word(reg_file[X_PC]);
    reg_file[X_IR] = ir;
    reg_file[X_PC] = reg_file[X_PC] + 16'd2;
    ra = {1'b0, ir[10:8]};
    rb = {1'b0, ir[7:5]};
    imm = {{8{ir[7]}}, ir[7:0]};
    disp = {{11{ir[4]}}, ir[4:0]};
    tgt = {4'h0, ir[11:0]};
    case (ir[15:14])
      GRP_FLOW: begin
        case (ir[12:11])
          FLOW_HALT: core_halted = 1'b1;
          FLOW_NOP: ;
          FLOW_RET: begin
            reg_file[X_SP] = reg_file[X_BP];
            reg_file[X_BP] = load_word(reg_file[X_SP]);
            reg_file[X_SP] = reg_file[X_SP] - 16'd2;
            reg_file[X_PC] = load_word(reg_file[X_SP]);
          end
          default: core_fault = 1'b1;
        endcase
      end
      GRP_XFER: begin
        case (ir[13:11])
          XFER_LODI: reg_file[ra] = imm;
          XFER_LODA: reg_file[ra] = load_word(imm);
          XFER_LODR: reg_file[ra] = load_word(reg_file[rb]);
          XFER_LODRD: reg_file[ra] = load_word(reg_file[rb] + disp);
          XFER_STOA: store_word(imm, reg_file[ra]);
          XFER_STOR: store_word(reg_file[rb], reg_file[ra]);
          XFER_STORD: store_word(reg_file[rb] + disp, reg_file[ra]);
          default: core_fault = 1'b1;
        endcase
      end
      GRP_ALU: begin
        case (ir[13:11])
          ALU_NEG: reg_file[X_AC] = 16'd0 - reg_file[ra];
          ALU_ADD: reg_file[X_AC] = reg_file[ra] + reg_file[rb];
          ALU_ADDI: reg_file[X_AC] = reg_file[ra] + imm;
          ALU_SUB: reg_file[X_AC] = reg_file[ra] - reg_file[rb];
          ALU_SUBI: reg_file[X_AC] = reg_file[ra] - imm;
          ALU_MOV: reg_file[ra] = reg_file[rb];
          default: core_fault = 1'b1;
        endcase
      end
      default: begin
        case (ir[13:12])
          JMP_ALWAYS: reg_file[X_PC] = tgt;
          JMP_ZERO: if (reg_file[X_AC] == 16'd0) reg_file[X_PC] = tgt;
          JMP_NEG: if (reg_file[X_AC][15]) reg_file[X_PC] = tgt;
          default: begin
            store_word(reg_file[X_SP], reg_file[X_PC]);
            reg_file[X_SP] = reg_file[X_SP] + 16'd2;
            reg_file[X_PC] = tgt;
            store_word(reg_file[X_SP], reg_file[X_BP]);
            reg_file[X_BP] = reg_file[X_SP];
            reg_file[X_SP] = reg_file[X_SP] + 16'd2;
          end
        endcase
      end
    endcase
  endfunction

  // predict the result of one accepted input beat
  function automatic core_result_t predict_result();
    core_result_t res;
    res.rd = 16'd0;
    case (kind)
      KIND_WRITE: store_word(mem_address, write_data);
      KIND_READ: res.rd = load_word(mem_address);
      KIND_INIT: begin
        foreach (reg_file[i]) reg_file[i] = 16'd0;
        reg_file[X_SP] = init_sp;
        reg_file[X_BP] = init_sp - 16'd2;
        reg_file[X_PC] = init_pc;
        core_halted = 1'b0;
        core_fault = 1'b0;
      end
      default: execute_instruction();
    endcase
    res.rv = (reg_select <= X_IR) ? reg_file[reg_select] : 16'd0;
    res.pc = reg_file[X_PC];
    res.ac = reg_file[X_AC];
    res.hlt = core_halted;
    res.flt = core_fault;
    return res;
  endfunction

  // print one line per mismatch and count it
  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    error_count++;
    $display("mismatch on %s: got %h, expected %h", what, got, want);
  endtask

  always @(posedge clk) begin
    core_result_t want;
    if (rst) begin
      foreach (reg_file[i]) reg_file[i] = 16'd0;
      foreach (mem_bytes[i]) mem_bytes[i] = 8'h00;
      core_halted = 1'b0;
      core_fault = 1'b0;
      init_sp = 16'd0;
      init_pc = 16'd0;
      expected_results.delete();
    end else begin
      // config writes
      if (cfg_we) begin
        if (cfg_index == CFG_SP) init_sp = cfg_data;
        else init_pc = cfg_data;
      end
      // output beat against the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result beat", read_data, 16'd0);
        end else begin
          want = expected_results.pop_front();
          if (read_data !== want.rd) report_mismatch("read_data", read_data, want.rd);
          if (reg_value !== want.rv) report_mismatch("reg_value", reg_value, want.rv);
          if (program_counter !== want.pc)
            report_mismatch("program_counter", program_counter, want.pc);
          if (accumulator !== want.ac)
            report_mismatch("accumulator", accumulator, want.ac);
          if (halted !== want.hlt) report_mismatch("halted", {15'd0, halted}, {15'd0, want.hlt});
          if (fault !== want.flt) report_mismatch("fault", {15'd0, fault}, {15'd0, want.flt});
        end
      end
      // input beat
      if (in_valid && in_ready) expected_results.push_back(predict_result());
    end
    outstanding <= expected_results.size();
    mismatches <= error_count;
  end

endmodule

@@ tb/accumulator_cpu_16bit_core_test.sv @@
// testbench top for the accumulator cpu core: clock, reset, stimulus, verdict
// depends on acpu_pkg, accumulator_cpu_16bit_core and acpu_core_checker
module accumulator_cpu_16bit_core_test;
  import acpu_pkg::*;

  localparam int CycleLimit = 1_000_000;
  localparam int PhaseItems = 240;
  localparam logic [15:0] ProgBase = 16'h0100;
  localparam logic [15:0] StackBase = 16'h0200;
  localparam int ProgWords = 36;

  // opcode field, bits 15:11
  localparam logic [4:0] OP_HALT = 5'b00000;
  localparam logic [4:0] OP_NOP = 5'b00001;
  localparam logic [4:0] OP_RET = 5'b00010;
  localparam logic [4:0] OP_FLOW_BAD = 5'b00011;
  localparam logic [4:0] OP_LODI = 5'b01000;
  localparam logic [4:0] OP_LODA = 5'b01001;
  localparam logic [4:0] OP_LODR = 5'b01010;
  localparam logic [4:0] OP_LODRD = 5'b01011;
  localparam logic [4:0] OP_STOA = 5'b01100;
  localparam logic [4:0] OP_STOR = 5'b01101;
  localparam logic [4:0] OP_STORD = 5'b01110;
  localparam logic [4:0] OP_XFER_BAD = 5'b01111;
  localparam logic [4:0] OP_NEG = 5'b10000;
  localparam logic [4:0] OP_ADD = 5'b10001;
  localparam logic [4:0] OP_ADDI = 5'b10010;
  localparam logic [4:0] OP_SUB = 5'b10011;
  localparam logic [4:0] OP_SUBI = 5'b10100;
  localparam logic [4:0] OP_ALU_BAD = 5'b10101;
  localparam logic [4:0] OP_MOV = 5'b10111;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind = KIND_WRITE;
  logic [15:0] mem_address = 16'd0;
  logic [15:0] write_data = 16'd0;
  logic [3:0]  reg_select = 4'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] read_data;
  logic [15:0] reg_value;
  logic [15:0] program_counter;
  logic [15:0] accumulator;
  logic        halted;
  logic        fault;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = CFG_SP;
  logic [15:0] cfg_data = 16'd0;
  int          mismatches;
  int          outstanding;
  int          cycle_count = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  logic [15:0] program_words[ProgWords];

  accumulator_cpu_16bit_core dut (.*);
  acpu_core_checker checker_inst (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver stalls
  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("accumulator_cpu_16bit_core test failed");
      $finish;
    end
  end

  function automatic logic [15:0] reg_op(input logic [4:0] op, input logic [2:0] ra,
                                         input logic [2:0] rb);
    return {op, ra, rb, 5'd0};
  endfunction

  function automatic logic [15:0] imm_op(input logic [4:0] op, input logic [2:0] ra,
                                         input logic [7:0] imm);
    return {op, ra, imm};
  endfunction

  function automatic logic [15:0] disp_op(input logic [4:0] op, input logic [2:0] ra,
                                          input logic [2:0] rb, input logic [4:0] d);
    return {op, ra, rb, d};
  endfunction

  function automatic logic [15:0] jump_op(input logic [1:0] c, input logic [11:0] tgt);
    return {GRP_JUMP, c, tgt};
  endfunction

  // one input beat, after a random sender gap
  task automatic send_beat(input logic [1:0] k, input logic [15:0] a,
                           input logic [15:0] d, input logic [3:0] s);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    kind <= k;
    mem_address <= a;
    write_data <= d;
    reg_select <= s;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold off the sender until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [0:0] idx, input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // new init values while idle, then an init beat
  task automatic reconfigure(input logic [15:0] sp, input logic [15:0] pc);
    drain();
    repeat (4) @(posedge clk);
    write_cfg(CFG_SP, sp);
    write_cfg(CFG_PC, pc);
    send_beat(KIND_INIT, 16'($urandom), 16'($urandom), 4'($urandom_range(15)));
  endtask

  task automatic random_beat();
    int pick;
    logic [15:0] a;
    logic [15:0] d;
    logic [3:0] s;
    pick = $urandom_range(99);
    a = $urandom_range(1) ? 16'($urandom_range(16'h0fff)) : 16'($urandom);
    d = 16'($urandom);
    s = 4'($urandom_range(15));
    if (pick < 8) send_beat(KIND_INIT, a, d, s);
    else if (pick < 58) send_beat(KIND_STEP, a, d, s);
    else if (pick < 82) send_beat(KIND_WRITE, a, d, s);
    else send_beat(KIND_READ, 16'($urandom), d, s);
  endtask

  initial begin
    int idle_sets[5];
    int stall_sets[5];
    logic [15:0] sp_sets[5];
    logic [15:0] pc_sets[5];

    // directed program; gaps hold random words
    foreach (program_words[i]) program_words[i] = 16'($urandom);
    program_words[0] = imm_op(OP_LODI, 3'd0, 8'h7f);
    program_words[1] = imm_op(OP_LODI, 3'd1, 8'h80);
    program_words[2] = reg_op(OP_ADD, 3'd0, 3'd1);
    program_words[3] = reg_op(OP_SUB, 3'd0, 3'd1);
    program_words[4] = reg_op(OP_NEG, 3'd1, 3'd0);
    program_words[5] = imm_op(OP_ADDI, 3'd0, 8'hff);
    program_words[6] = imm_op(OP_SUBI, 3'd0, 8'h80);
    program_words[7] = reg_op(OP_MOV, 3'd2, 3'd1);
    program_words[8] = imm_op(OP_STOA, 3'd0, 8'h10);
    program_words[9] = imm_op(OP_LODA, 3'd3, 8'h10);
    program_words[10] = imm_op(OP_LODI, 3'd2, 8'h40);
    program_words[11] = reg_op(OP_STOR, 3'd0, 3'd2);
    program_words[12] = reg_op(OP_LODR, 3'd3, 3'd2);
    program_words[13] = disp_op(OP_STORD, 3'd1, 3'd2, 5'h1f);
    program_words[14] = disp_op(OP_LODRD, 3'd3, 3'd2, 5'h1f);
    program_words[15] = jump_op(JMP_CALL, 12'h140);
    program_words[16] = reg_op(OP_SUB, 3'd0, 3'd0);
    program_words[17] = jump_op(JMP_ZERO, 12'h126);
    program_words[19] = jump_op(JMP_NEG, 12'h100);
    program_words[20] = jump_op(JMP_ALWAYS, 12'h12c);
    program_words[22] = reg_op(OP_FLOW_BAD, 3'd0, 3'd0);
    program_words[23] = reg_op(OP_XFER_BAD, 3'd0, 3'd0);
    program_words[24] = reg_op(OP_ALU_BAD, 3'd0, 3'd0);
    program_words[25] = reg_op(OP_HALT, 3'd0, 3'd0);
    program_words[32] = reg_op(OP_NOP, 3'd0, 3'd0);
    program_words[33] = reg_op(OP_RET, 3'd0, 3'd0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // load the directed program; the rest of memory reads as zero after reset
    for (int i = 0; i < ProgWords; i++)
      send_beat(KIND_WRITE, ProgBase + 16'(2 * i), program_words[i],
                4'($urandom_range(15)));

    // directed run through the program, past halt
    reconfigure(StackBase, ProgBase);
    for (int i = 0; i < 28; i++) send_beat(KIND_STEP, 16'($urandom), 16'($urandom), 4'(i));
    send_beat(KIND_READ, 16'hffff, 16'($urandom), 4'hf);
    send_beat(KIND_READ, StackBase, 16'($urandom), X_IR);

    // random phases: sender idle / receiver stall mixes and init settings
    idle_sets = '{0, 88, 0, 27, 0};
    stall_sets = '{0, 0, 88, 27, 0};
    sp_sets = '{16'h0000, 16'hffff, 16'($urandom), 16'h0ffe, 16'($urandom)};
    pc_sets = '{16'h0000, 16'hffff, 16'($urandom_range(16'h0fff)), 16'h0fff,
                16'($urandom)};
    for (int p = 0; p < 5; p++) begin
      idle_pct = idle_sets[p];
      stall_pct = stall_sets[p];
      reconfigure(sp_sets[p], pc_sets[p]);
      for (int i = 0; i < PhaseItems; i++) begin
        if (p == 2 && i == PhaseItems / 2) drain();
        random_beat();
      end
    end

    // wind down
    in_valid <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("accumulator_cpu_16bit_core test passed");
    else
      $display("accumulator_cpu_16bit_core test failed");
    $finish;
  end

endmodule
